>>> rtl/slt_pkg.sv
// Shared types and codes for the sorted list table.
// Used by slt_ctrl, slt_datapath and sorted_list_table_unit; depends on nothing.
package slt_pkg;

    // Operation codes carried in a request
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] position;
        logic [4:0] count;
    } out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch request and register per-entry compares
        logic commit;   // apply the shift and load the result register
    } cmd_t;

endpackage

>>> rtl/sorted_list_table_unit.sv
// Sorted list table: keeps up to CAPACITY 8-bit values in ascending order.
// Input channel s_* carries a request {operation, value}: insert, delete the
// first equal entry, or search for the first equal entry.
// Output channel m_* carries one result per request {status, position, count}:
// status 0 done/found, 1 not found, 2 full on insert; position is the index of
// the entry inserted, deleted or found (0 when not found); count is the number
// of entries after the request.
// Flow: on acceptance the request and the compare stage (all cells against
// the value) are registered; the shift stage of the cell row then applies the
// shift and loads the result register, which raises m_valid. A new request is
// taken only once the shift stage of the previous one has completed.
// A result waiting on m_ready does not stop the next request from being
// accepted and compared; only its shift stage waits until the held result
// is taken.
// Reset (aresetn low, synchronous) empties the list and drops any pending result.
// Depends on slt_pkg, slt_ctrl and slt_datapath.
module sorted_list_table_unit #(
    parameter int CAPACITY = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  slt_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output slt_pkg::out_t m_data
);

    slt_pkg::cmd_t cmd;

    slt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    slt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

>>> rtl/slt_ctrl.sv
// Controller for the sorted list table: request handshake, result valid, commands.
// Depends on slt_pkg.
module slt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output slt_pkg::cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Commands: capture on accept, commit once the result register is free
    always_comb begin
        cmd.capture = (state_reg == S_IDLE) && s_valid;
        cmd.commit  = (state_reg == S_UPDATE) && (!m_valid_reg || m_ready);
    end

    // Next state and result valid
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (cmd.commit) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> rtl/slt_datapath.sv
// Datapath for the sorted list table: row of entry cells with per-cell compare,
// shift on insert/delete, and the result register. Depends on slt_pkg.
module slt_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  slt_pkg::cmd_t cmd,
    input  slt_pkg::in_t  s_data,
    output slt_pkg::out_t m_data
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Entry cells; contents above the count are don't-care
    logic [7:0]          entry_reg  [CAPACITY];
    logic [7:0]          entry_next [CAPACITY];
    logic [CW-1:0]       count_reg, count_next;

    // Latched request and compare flags
    logic [1:0]          op_reg;
    logic [7:0]          val_reg;
    logic [CAPACITY-1:0] lt_reg, lt_next;
    logic                hit_reg, hit_next;

    slt_pkg::out_t       result_reg, result_next;

    logic [CAPACITY-1:0] bound;
    logic [IW-1:0]       pos_idx;
    logic                full;
    logic [31:0]         pos_ext;
    logic [31:0]         cnt_ext;

    // Per-cell compare against the incoming value
    always_comb begin
        hit_next = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            lt_next[i] = (CW'(i) < count_reg) && (entry_reg[i] < s_data.value);
            if ((CW'(i) < count_reg) && (entry_reg[i] == s_data.value)) begin
                hit_next = 1'b1;
            end
        end
    end

    // Lower-bound marker: the less-than flags form a prefix, so at most one cell is marked
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == 0) begin
                bound[i] = !lt_reg[i];
            end else begin
                bound[i] = !lt_reg[i] && lt_reg[i-1];
            end
        end
    end

    // One-hot to index
    always_comb begin
        pos_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (bound[i]) begin
                pos_idx = pos_idx | IW'(i);
            end
        end
    end

    assign full    = (count_reg == CW'(CAPACITY));
    assign pos_ext = 32'(pos_idx);

    // Shift network and result
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            entry_next[i] = entry_reg[i];
        end
        count_next         = count_reg;
        result_next.status = slt_pkg::ST_MISSING;
        result_next.position = 5'd0;

        case (op_reg)
            slt_pkg::OP_INSERT: begin
                if (full) begin
                    result_next.status = slt_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (!lt_reg[i]) begin
                            if (bound[i]) begin
                                entry_next[i] = val_reg;
                            end else if (i > 0) begin
                                entry_next[i] = entry_reg[i-1];
                            end
                        end
                    end
                    count_next           = count_reg + CW'(1);
                    result_next.status   = slt_pkg::ST_DONE;
                    result_next.position = pos_ext[4:0];
                end
            end
            slt_pkg::OP_DELETE: begin
                if (hit_reg) begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (!lt_reg[i]) begin
                            entry_next[i] = entry_reg[i+1];
                        end
                    end
                    count_next           = count_reg - CW'(1);
                    result_next.status   = slt_pkg::ST_DONE;
                    result_next.position = pos_ext[4:0];
                end
            end
            slt_pkg::OP_SEARCH: begin
                if (hit_reg) begin
                    result_next.status   = slt_pkg::ST_DONE;
                    result_next.position = pos_ext[4:0];
                end
            end
            default: begin
                result_next.status = slt_pkg::ST_MISSING;
            end
        endcase

        cnt_ext           = 32'(count_next);
        result_next.count = cnt_ext[4:0];
    end

    // Count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_data.operation;
            val_reg <= s_data.value;
            lt_reg  <= lt_next;
            hit_reg <= hit_next;
        end
        if (cmd.commit) begin
            result_reg <= result_next;
            for (int i = 0; i < CAPACITY; i++) begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    assign m_data = result_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && (op_reg == slt_pkg::OP_INSERT) && !full
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the count");

    a_search_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && (op_reg == slt_pkg::OP_SEARCH)
        |=> count_reg == $past(count_reg))
        else $error("search changed the count");

    a_bound_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> $onehot0(bound))
        else $error("lower-bound marker not one-hot");

endmodule
